FILE: rtl/idxsa_pkg.sv
// ----------------------------------------------------------------------------
// idxsa_pkg
// shared types and constants for the indexed shift array: command and status
// codes, per-cell operation codes and the control bundle broadcast to the cells
// ----------------------------------------------------------------------------
package idxsa_pkg;

   localparam int CMD_W    = 2;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // what every cell does at the next edge
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_MATCH  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

FILE: rtl/idxsa_if.sv
// ----------------------------------------------------------------------------
// idxsa channel interfaces
// valid/ready channels for command beats and response beats
// ----------------------------------------------------------------------------
interface idxsa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [idxsa_pkg::CMD_W-1:0]          command;
   logic [idxsa_pkg::POS_W-1:0]          position;
   logic signed [idxsa_pkg::VALUE_W-1:0] value;

   modport source (output valid, output command, output position, output value,
                   input ready);
   modport sink   (input valid, input command, input position, input value,
                   output ready);
endinterface

interface idxsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [idxsa_pkg::STATUS_W-1:0] status;
   logic                           found;
   logic [idxsa_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output found, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found, input entry_count,
                   output ready);
endinterface

FILE: rtl/idxsa_cell.sv
// ----------------------------------------------------------------------------
// idxsa_cell
// one storage slot of the array: shifts up, shifts down, loads the new value
// or compares its entry against the search key
// ----------------------------------------------------------------------------
module idxsa_cell #(
   parameter int CMP_W = 7,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  idxsa_pkg::cell_ctl_type              ctl,
   input  logic [CMP_W-1:0]                     count,
   input  logic signed [idxsa_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [idxsa_pkg::VALUE_W-1:0] right_entry,
   output logic signed [idxsa_pkg::VALUE_W-1:0] entry,
   output logic                                 match
);

   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic signed [idxsa_pkg::VALUE_W-1:0] entry_ff;
   logic signed [idxsa_pkg::VALUE_W-1:0] entry_in;
   logic                                 match_ff;
   logic [CMP_W-1:0]                     pos;

   assign pos = CMP_W'(ctl.position);

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         idxsa_pkg::OP_INSERT: begin
            if (IDX > pos) begin
               entry_in = left_entry;
            end else if (IDX == pos) begin
               entry_in = ctl.value;
            end
         end
         idxsa_pkg::OP_REMOVE: begin
            if (IDX >= pos) begin
               entry_in = right_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      // only held entries may match
      if (ctl.op == idxsa_pkg::OP_MATCH) begin
         match_ff <= (entry_ff == ctl.value) && (IDX < count);
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

FILE: rtl/idxsa_match_tree.sv
// ----------------------------------------------------------------------------
// idxsa_match_tree
// registered or-reduction of the per-cell match flags in groups of 32
// ----------------------------------------------------------------------------
module idxsa_match_tree #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] match,
   output logic             found
);

   localparam int GROUP_W = 32;
   localparam int NGROUP  = (WIDTH + GROUP_W - 1) / GROUP_W;

   logic [NGROUP-1:0] group_ff;

   for (genvar g = 0; g < NGROUP; g++) begin : g_group
      localparam int LO = g * GROUP_W;
      localparam int HI = ((LO + GROUP_W) < WIDTH) ? (LO + GROUP_W - 1) : (WIDTH - 1);
      always_ff @(posedge clock) begin
         group_ff[g] <= |match[HI:LO];
      end
   end

   assign found = |group_ff;

endmodule

FILE: rtl/indexed_shift_array_top.sv
// a command beat is accepted only in idle; its cells update at the accept edge,
// the registered group-or stage of the search tree follows, then the response load
// (done waits for a free response slot); no new command is taken before that load
// the response register frees the next command while a response waits
// reset: synchronous, active high; clears the count, the sequencer and rsp valid
// ----------------------------------------------------------------------------
// indexed_shift_array_top
// ordered store of signed 32-bit entries held in a row of shifting cells;
// insert, remove, search and clear commands with one response beat each
// ----------------------------------------------------------------------------
module indexed_shift_array_top #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   idxsa_req_if.sink   req_ch,
   idxsa_rsp_if.source rsp_ch
);

   // count needs to reach CAPACITY itself; compares run at least as wide
   // as the 7-bit position field
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > idxsa_pkg::POS_W) ? CNT_W : idxsa_pkg::POS_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_GROUP = 3'b010,
      S_DONE  = 3'b100
   } state_type;

   typedef logic signed [idxsa_pkg::VALUE_W-1:0] value_type;

   // sequencer and count
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // pending result of the command in flight
   idxsa_pkg::status_type status_ff, status_in;
   logic                  search_ff, search_in;

   // response register
   logic                            rsp_valid_ff;
   logic [idxsa_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic                            rsp_found_ff;
   logic [idxsa_pkg::COUNT_W-1:0]   rsp_count_ff;

   logic                    accept;
   logic                    rsp_free;
   logic                    load_rsp;
   logic                    full;
   logic [CMP_W-1:0]        pos_cmp;
   logic [CMP_W-1:0]        count_cmp;
   idxsa_pkg::cell_op_type  op;
   idxsa_pkg::cell_ctl_type ctl;
   value_type               entry [CAPACITY];
   logic [CAPACITY-1:0]     match;
   logic                    tree_found;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // response slot is free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign load_rsp = (state_ff == S_DONE) && rsp_free;

   assign pos_cmp   = CMP_W'(req_ch.position);
   assign count_cmp = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   // command decode: checks use the count before the command
   always_comb begin
      op        = idxsa_pkg::OP_HOLD;
      status_in = idxsa_pkg::ST_OK;
      search_in = 1'b0;
      count_in  = count_ff;
      unique case (idxsa_pkg::command_type'(req_ch.command))
         idxsa_pkg::CMD_INSERT: begin
            // full wins over a bad position
            if (full) begin
               status_in = idxsa_pkg::ST_FULL;
            end else if (pos_cmp > count_cmp) begin
               status_in = idxsa_pkg::ST_BADPOS;
            end else begin
               op       = idxsa_pkg::OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         idxsa_pkg::CMD_REMOVE: begin
            // empty wins over a bad position
            if (count_ff == '0) begin
               status_in = idxsa_pkg::ST_EMPTY;
            end else if (pos_cmp >= count_cmp) begin
               status_in = idxsa_pkg::ST_BADPOS;
            end else begin
               op       = idxsa_pkg::OP_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         idxsa_pkg::CMD_SEARCH: begin
            op        = idxsa_pkg::OP_MATCH;
            search_in = 1'b1;
         end
         idxsa_pkg::CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // broadcast to the cells; they only act on an accepted beat
   assign ctl.op       = accept ? op : idxsa_pkg::OP_HOLD;
   assign ctl.position = req_ch.position;
   assign ctl.value    = req_ch.value;

   // row of cells, each fed by its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type left_entry;
      value_type right_entry;

      if (i == 0) begin : g_first
         // cell 0 never takes from the left
         assign left_entry = req_ch.value;
      end else begin : g_left
         assign left_entry = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         // last cell keeps its own entry on a remove
         assign right_entry = entry[i];
      end else begin : g_right
         assign right_entry = entry[i+1];
      end

      idxsa_cell #(
         .CMP_W (CMP_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_cmp),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry[i]),
         .match       (match[i])
      );
   end

   // match flags settle at the accept edge, group ors at the edge after
   idxsa_match_tree #(
      .WIDTH (CAPACITY)
   ) u_match_tree (
      .clock (clock),
      .match (match),
      .found (tree_found)
   );

   // sequencer: idle -> group reduce -> done (waits for a free response slot)
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_GROUP;
            end
         end
         S_GROUP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            count_ff <= count_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         search_ff <= search_in;
      end
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= search_ff && tree_found;
         // count reported modulo 128
         rsp_count_ff  <= count_cmp[idxsa_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for indexed_shift_array_top: a queue-fed driver sends
// directed and random command beats with random idle bursts, a scoreboard
// store predicts each response and a monitor checks every response beat
// ----------------------------------------------------------------------------
module tb;

   localparam int STORE_DEPTH = 64;

   typedef struct {
      idxsa_pkg::command_type                cmd;
      logic [idxsa_pkg::POS_W-1:0]          pos;
      logic signed [idxsa_pkg::VALUE_W-1:0] val;
   } cmd_beat_type;

   typedef struct {
      idxsa_pkg::status_type         status;
      logic                          found;
      logic [idxsa_pkg::COUNT_W-1:0] count;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   idxsa_req_if req_ch ();
   idxsa_rsp_if rsp_ch ();

   indexed_shift_array_top #(
      .CAPACITY (STORE_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #2 clock = ~clock;

   // command beats still to send, and predicted responses still to arrive
   cmd_beat_type cmd_backlog[$];
   outcome_type  outcome_queue[$];

   // scoreboard copy of the store
   logic signed [idxsa_pkg::VALUE_W-1:0] held_values[STORE_DEPTH];
   int                                   held_total = 0;

   // count as seen while building the stimulus, used to aim positions
   int gen_count = 0;
   int n_queued  = 0;
   logic signed [idxsa_pkg::VALUE_W-1:0] value_pool[16];

   int           mismatches = 0;
   int           beats_sent = 0;
   int           send_gap   = 0;
   int           take_gap   = 0;
   int           send_rate  = 10;
   int           take_rate  = 10;
   cmd_beat_type beat_on_bus;

   // --------------------------------------------------------------------------
   // scoreboard store: applies one command and returns the response it gives
   // --------------------------------------------------------------------------
   function automatic outcome_type apply_to_store(cmd_beat_type b);
      outcome_type o;
      int          i;
      o.status = idxsa_pkg::ST_OK;
      o.found  = 1'b0;
      case (b.cmd)
         idxsa_pkg::CMD_INSERT: begin
            // full wins over a bad position
            if (held_total >= STORE_DEPTH) begin
               o.status = idxsa_pkg::ST_FULL;
            end else if (int'(b.pos) > held_total) begin
               o.status = idxsa_pkg::ST_BADPOS;
            end else begin
               for (i = held_total; i > int'(b.pos); i--)
                  held_values[i] = held_values[i-1];
               held_values[b.pos] = b.val;
               held_total++;
            end
         end
         idxsa_pkg::CMD_REMOVE: begin
            // empty wins over a bad position
            if (held_total == 0) begin
               o.status = idxsa_pkg::ST_EMPTY;
            end else if (int'(b.pos) >= held_total) begin
               o.status = idxsa_pkg::ST_BADPOS;
            end else begin
               for (i = int'(b.pos); i + 1 < held_total; i++)
                  held_values[i] = held_values[i+1];
               held_total--;
            end
         end
         idxsa_pkg::CMD_SEARCH: begin
            // stale entries past the count never match
            for (i = 0; i < held_total; i++)
               if (held_values[i] == b.val) o.found = 1'b1;
         end
         default: begin
            held_total = 0;
         end
      endcase
      o.count = idxsa_pkg::COUNT_W'(held_total);
      return o;
   endfunction

   // --------------------------------------------------------------------------
   // stimulus building
   // --------------------------------------------------------------------------
   task automatic queue_cmd(idxsa_pkg::command_type c, int p,
                            logic [idxsa_pkg::VALUE_W-1:0] v);
      cmd_beat_type b;
      b.cmd = c;
      b.pos = idxsa_pkg::POS_W'(p);
      b.val = v;
      cmd_backlog.push_back(b);
      n_queued++;
      // track the count so later positions land in range most of the time
      case (c)
         idxsa_pkg::CMD_INSERT: if (gen_count < STORE_DEPTH && p <= gen_count) gen_count++;
         idxsa_pkg::CMD_REMOVE: if (gen_count > 0 && p < gen_count) gen_count--;
         idxsa_pkg::CMD_CLEAR:  gen_count = 0;
         default:    ;
      endcase
   endtask

   function automatic logic [idxsa_pkg::VALUE_W-1:0] pick_value();
      // pooled values make searches hit and duplicates appear
      if ($urandom_range(0, 99) < 45) return value_pool[$urandom_range(0, 15)];
      return $urandom;
   endfunction

   function automatic int pick_insert_pos();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, gen_count);
      if (r < 88) return 0;
      if (r < 94) return gen_count;
      return $urandom_range(0, 127);
   endfunction

   function automatic int pick_remove_pos();
      int r;
      r = $urandom_range(0, 99);
      if (gen_count == 0) return $urandom_range(0, 127);
      if (r < 80) return $urandom_range(0, gen_count - 1);
      if (r < 86) return gen_count - 1;
      if (r < 92) return gen_count;              // one past the last entry
      return $urandom_range(0, 127);
   endfunction

   // idle burst start chance in percent, zero gives stretches with no idling
   function automatic int pick_rate();
      case ($urandom_range(0, 4))
         0, 1:    return 0;
         2:       return 5;
         3:       return 15;
         default: return 40;
      endcase
   endfunction

   // no idling once the end of the stimulus is near
   function automatic bit bursts_allowed();
      return cmd_backlog.size() > 200;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // --------------------------------------------------------------------------
   // driver: one command beat on the bus at a time, random idle bursts
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         next_valid = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            // beat accepted: predict its response now
            outcome_queue.push_back(apply_to_store(beat_on_bus));
            beats_sent++;
            if (beats_sent % 128 == 0) begin
               send_rate = pick_rate();
               take_rate = pick_rate();
            end
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (cmd_backlog.size() != 0) begin
               if (bursts_allowed() && $urandom_range(0, 99) < send_rate) begin
                  // start an idle burst instead of sending a beat
                  send_gap = $urandom_range(0, 12);
               end else begin
                  beat_on_bus = cmd_backlog.pop_front();
                  req_ch.command  <= beat_on_bus.cmd;
                  req_ch.position <= beat_on_bus.pos;
                  req_ch.value    <= beat_on_bus.val;
                  next_valid = 1'b1;
               end
            end
         end
         // single update of valid per edge, so back-to-back beats stay high
         req_ch.valid <= next_valid;
      end
   end

   // --------------------------------------------------------------------------
   // monitor: checks each response beat against the oldest prediction
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type want;
      logic        next_ready;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_queue.size() == 0) begin
               mismatches++;
               $display("%0t: extra response, expected none actual %0d %0d %0d",
                        $time, rsp_ch.status, rsp_ch.found, rsp_ch.entry_count);
            end else begin
               want = outcome_queue.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("found", want.found, rsp_ch.found);
               check_field("entry_count", want.count, rsp_ch.entry_count);
            end
         end
         // random back-pressure bursts
         if (take_gap > 0) begin
            take_gap--;
            next_ready = 1'b0;
         end else if (bursts_allowed() && $urandom_range(0, 99) < take_rate) begin
            take_gap   = $urandom_range(0, 12);
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // --------------------------------------------------------------------------
   // stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin
      int ins_w;
      int r;
      int k;

      // known values on every input before the first edge
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.command  = idxsa_pkg::CMD_INSERT;
      req_ch.position = '0;
      req_ch.value    = '0;
      rsp_ch.ready    = 1'b0;

      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      value_pool[4] = 32'h0000_0001;
      for (k = 5; k < 16; k++) value_pool[k] = $urandom;

      // directed: empty store corner cases
      queue_cmd(idxsa_pkg::CMD_REMOVE, 0, 32'h0);            // empty
      queue_cmd(idxsa_pkg::CMD_REMOVE, 127, 32'h0);          // empty beats bad position
      queue_cmd(idxsa_pkg::CMD_SEARCH, 0, 32'h0);            // nothing held
      queue_cmd(idxsa_pkg::CMD_INSERT, 1, 32'h1);            // past the count
      queue_cmd(idxsa_pkg::CMD_INSERT, 127, 32'h1);          // far past the count
      // build [0, min, -1, max] through front, middle and end inserts
      queue_cmd(idxsa_pkg::CMD_INSERT, 0, 32'h8000_0000);
      queue_cmd(idxsa_pkg::CMD_INSERT, 1, 32'h7fff_ffff);
      queue_cmd(idxsa_pkg::CMD_INSERT, 1, 32'hffff_ffff);
      queue_cmd(idxsa_pkg::CMD_INSERT, 0, 32'h0);
      queue_cmd(idxsa_pkg::CMD_SEARCH, 0, 32'h8000_0000);
      queue_cmd(idxsa_pkg::CMD_SEARCH, 0, 32'h7fff_ffff);
      queue_cmd(idxsa_pkg::CMD_SEARCH, 127, 32'h1234_5678);  // miss, position ignored
      queue_cmd(idxsa_pkg::CMD_REMOVE, 4, 32'h0);            // at the count
      queue_cmd(idxsa_pkg::CMD_REMOVE, 127, 32'h0);
      queue_cmd(idxsa_pkg::CMD_REMOVE, 3, 32'h0);            // last entry
      queue_cmd(idxsa_pkg::CMD_SEARCH, 0, 32'h7fff_ffff);    // stale slot must not match
      queue_cmd(idxsa_pkg::CMD_REMOVE, 0, 32'h0);            // front entry
      queue_cmd(idxsa_pkg::CMD_INSERT, 2, 32'h5555_5555);    // append at the count
      queue_cmd(idxsa_pkg::CMD_INSERT, 3, 32'haaaa_aaaa);
      queue_cmd(idxsa_pkg::CMD_CLEAR, 99, 32'hdead_beef);
      queue_cmd(idxsa_pkg::CMD_SEARCH, 0, 32'hffff_ffff);    // cleared entries are gone
      queue_cmd(idxsa_pkg::CMD_REMOVE, 0, 32'h0);            // empty after clear
      queue_cmd(idxsa_pkg::CMD_INSERT, 0, 32'h7);
      queue_cmd(idxsa_pkg::CMD_SEARCH, 0, 32'h7);

      // random: fill episodes reach the full store, mixed chunks churn
      while (n_queued < 24 + 1850) begin
         if ($urandom_range(0, 3) == 0) begin
            while (gen_count < STORE_DEPTH) begin
               if ($urandom_range(0, 9) == 0)
                  queue_cmd(idxsa_pkg::CMD_SEARCH, 0, pick_value());
               else
                  queue_cmd(idxsa_pkg::CMD_INSERT, pick_insert_pos(), pick_value());
            end
            // full store, any position
            repeat ($urandom_range(2, 5))
               queue_cmd(idxsa_pkg::CMD_INSERT, $urandom_range(0, 127), pick_value());
            repeat (4)
               queue_cmd(idxsa_pkg::CMD_SEARCH, $urandom_range(0, 127), pick_value());
            if ($urandom_range(0, 2) == 0) begin
               queue_cmd(idxsa_pkg::CMD_CLEAR, $urandom_range(0, 127), pick_value());
            end else begin
               while (gen_count > 0) begin
                  if ($urandom_range(0, 7) == 0)
                     queue_cmd(idxsa_pkg::CMD_SEARCH, 0, pick_value());
                  else
                     queue_cmd(idxsa_pkg::CMD_REMOVE, pick_remove_pos(), pick_value());
               end
            end
            queue_cmd(idxsa_pkg::CMD_REMOVE, $urandom_range(0, 127), pick_value());
         end else begin
            case ($urandom_range(0, 2))
               0:       ins_w = 25;
               1:       ins_w = 45;
               default: ins_w = 60;
            endcase
            repeat (40) begin
               r = $urandom_range(0, 99);
               if (r < ins_w)
                  queue_cmd(idxsa_pkg::CMD_INSERT, pick_insert_pos(), pick_value());
               else if (r < ins_w + 30)
                  queue_cmd(idxsa_pkg::CMD_REMOVE, pick_remove_pos(), pick_value());
               else if (r < 97)
                  queue_cmd(idxsa_pkg::CMD_SEARCH, $urandom_range(0, 127), pick_value());
               else
                  queue_cmd(idxsa_pkg::CMD_CLEAR, $urandom_range(0, 127), pick_value());
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain: all beats sent and every response back
      while (cmd_backlog.size() != 0 || req_ch.valid || outcome_queue.size() != 0)
         @(posedge clock);
      // then keep clocking to catch any extra response beat
      repeat (8) @(posedge clock);

      if (outcome_queue.size() != 0) begin
         mismatches++;
         $display("%0t: %0d responses missing, expected %0d actual 0",
                  $time, outcome_queue.size(), outcome_queue.size());
      end

      if (mismatches == 0)
         $display("indexed_shift_array_top test passed");
      else
         $display("indexed_shift_array_top test failed");
      $finish;
   end

   // hang guard, well past the slowest legal run
   initial begin
      #2000000;
      $display("indexed_shift_array_top test failed");
      $finish;
   end

endmodule
